>>> rtl/core/multilevel_feedback_scheduler_macros.svh
// Assertion macros for the scheduler.
`ifndef MULTILEVEL_FEEDBACK_SCHEDULER_MACROS_SVH
`define MULTILEVEL_FEEDBACK_SCHEDULER_MACROS_SVH
`ifndef SYNTHESIS
`define MFS_ASSERT_IMP(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("assertion failed");
`define MFS_ASSERT_NXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define MFS_ASSERT_IMP(label, clk, rstn, ante, cons)
`define MFS_ASSERT_NXT(label, clk, rstn, ante, cons)
`endif
`endif

>>> rtl/core/mfs_pkg.sv
`timescale 1ns / 1ps
package mfs_pkg;
    localparam logic [29:0] NS_PER_SEC = 30'd1000000000;
    localparam logic [29:0] MAX_NS     = 30'd999999999;

    localparam logic [2:0] ST_IDLE     = 3'd0;
    localparam logic [2:0] ST_DISPATCH = 3'd1;
    localparam logic [2:0] ST_FREED    = 3'd2;
    localparam logic [2:0] ST_BLOCKED  = 3'd3;
    localparam logic [2:0] ST_DEMOTED  = 3'd4;
    localparam logic [2:0] ST_IGNORED  = 3'd5;

    localparam logic [1:0] REG_BASE  = 2'd0;
    localparam logic [1:0] REG_IDLE  = 2'd1;
    localparam logic [1:0] REG_COST  = 2'd2;
    localparam logic [1:0] REG_WAIT  = 2'd3;

    typedef struct packed {
        logic [31:0] sec;
        logic [29:0] ns;
    } mfs_time_t;

    function automatic mfs_time_t clock_add(mfs_time_t t, logic [29:0] add);
        logic [30:0] s;
        mfs_time_t r;
        s = {1'b0, t.ns} + {1'b0, add};
        if (s >= {1'b0, NS_PER_SEC}) begin
            r.ns  = 30'(s - {1'b0, NS_PER_SEC});
            r.sec = t.sec + 32'd1;
        end else begin
            r.ns  = s[29:0];
            r.sec = t.sec;
        end
        return r;
    endfunction

    function automatic logic [29:0] quantum_for(logic [27:0] base, logic [1:0] lvl);
        logic [31:0] q;
        q = {4'd0, base} << lvl;
        return (q > {2'd0, MAX_NS}) ? MAX_NS : q[29:0];
    endfunction
endpackage

>>> rtl/core/mfs_core.sv
`timescale 1ns / 1ps
`include "multilevel_feedback_scheduler_macros.svh"
module mfs_core
    import mfs_pkg::*;
#(
    parameter int SLOTS = 32
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        start,
    input  logic        op,
    input  logic        admit,
    input  logic [29:0] used_ns,
    input  logic        term,
    input  logic [27:0] base_q,
    input  logic [29:0] idle_adv,
    input  logic [29:0] disp_cost,
    input  logic [7:0]  wait_sec,
    output logic        busy,
    output logic        done,
    output logic [2:0]  r_status,
    output logic [4:0]  r_slot,
    output logic [29:0] r_quantum,
    output logic        r_admitted,
    output logic [4:0]  r_admit_slot,
    output mfs_time_t   r_clock
);
    localparam int SW = $clog2(SLOTS);
    localparam int CW = $clog2(SLOTS + 1);
    localparam int QD = 3 * SLOTS;
    localparam int QW = $clog2(QD);

    typedef enum logic [2:0] {
        S_IDLE, S_SCAN, S_WAKE_CHK, S_ADMIT, S_DISP, S_DISP_RD, S_REPORT, S_BLK_FIND
    } state_t;

    state_t state_reg;

    // wake memory
    mfs_time_t wake_mem [SLOTS];
    logic [SW-1:0] wk_raddr;
    mfs_time_t wk_rdata;
    logic wk_we;
    logic [SW-1:0] wk_waddr;
    mfs_time_t wk_wdata;
    always_ff @(posedge aclk) begin
        if (wk_we) wake_mem[wk_waddr] <= wk_wdata;
        wk_rdata <= wake_mem[wk_raddr];
    end

    // ready queue memory, three circular regions
    logic [SW-1:0] q_mem [QD];
    logic q_we;
    logic [QW-1:0] q_waddr, q_raddr;
    logic [SW-1:0] q_wdata, q_rdata;
    always_ff @(posedge aclk) begin
        if (q_we) q_mem[q_waddr] <= q_wdata;
        q_rdata <= q_mem[q_raddr];
    end

    logic [SW-1:0] head_reg [3];
    logic [CW-1:0] cnt_reg [3];
    logic [SLOTS-1:0] in_use_reg;
    logic [SLOTS-1:0] blk_v_reg;
    logic [SW-1:0] blk_s_reg [SLOTS];
    mfs_time_t clk_reg;
    logic [SW-1:0] run_slot_reg;
    logic [1:0] run_lvl_reg;
    logic pend_reg;
    logic [SW-1:0] idx_reg;
    logic [1:0] lvl_reg;
    logic admit_reg, term_reg;
    logic [29:0] used_reg;

    function automatic logic [QW-1:0] qaddr(logic [1:0] l, logic [SW-1:0] p);
        return QW'(l) * QW'(SLOTS) + QW'(p);
    endfunction

    function automatic logic [SW-1:0] pos_add(logic [SW-1:0] h, logic [CW-1:0] c);
        logic [SW:0] s;
        s = {1'b0, h} + (SW+1)'(c);
        if (s >= (SW+1)'(SLOTS)) s = s - (SW+1)'(SLOTS);
        return s[SW-1:0];
    endfunction

    logic [SW-1:0] free_idx;
    logic free_any;
    always_comb begin
        free_idx = '0;
        free_any = 1'b0;
        for (int i = SLOTS - 1; i >= 0; i--) begin
            if (!in_use_reg[i]) begin
                free_idx = SW'(i);
                free_any = 1'b1;
            end
        end
    end

    logic [SW-1:0] blk_free;
    always_comb begin
        blk_free = '0;
        for (int i = SLOTS - 1; i >= 0; i--) begin
            if (!blk_v_reg[i]) blk_free = SW'(i);
        end
    end

    logic expired;
    assign expired = (wk_rdata.sec < clk_reg.sec) ||
                     (wk_rdata.sec == clk_reg.sec && wk_rdata.ns < clk_reg.ns);

    logic [29:0] rep_q;
    assign rep_q = quantum_for(base_q, run_lvl_reg);
    mfs_time_t rep_clk;
    assign rep_clk = clock_add(clk_reg, used_reg);
    logic [1:0] dem_lvl;
    assign dem_lvl = (run_lvl_reg == 2'd2) ? 2'd2 : run_lvl_reg + 2'd1;

    logic [1:0] sel_lvl;
    logic sel_any;
    always_comb begin
        sel_any = 1'b1;
        if (cnt_reg[0] != '0)      sel_lvl = 2'd0;
        else if (cnt_reg[1] != '0) sel_lvl = 2'd1;
        else if (cnt_reg[2] != '0) sel_lvl = 2'd2;
        else begin
            sel_lvl = 2'd0;
            sel_any = 1'b0;
        end
    end

    always_comb begin
        wk_raddr = blk_s_reg[idx_reg];
        wk_we = 1'b0;
        wk_waddr = run_slot_reg;
        wk_wdata.sec = rep_clk.sec + {24'd0, wait_sec};
        wk_wdata.ns = rep_clk.ns;
        q_we = 1'b0;
        q_waddr = '0;
        q_wdata = '0;
        q_raddr = qaddr(sel_lvl, head_reg[sel_lvl]);
        unique case (state_reg)
            S_WAKE_CHK: begin
                q_we = blk_v_reg[idx_reg] && expired && cnt_reg[0] < CW'(SLOTS);
                q_waddr = qaddr(2'd0, pos_add(head_reg[0], cnt_reg[0]));
                q_wdata = blk_s_reg[idx_reg];
            end
            S_ADMIT: begin
                q_we = admit_reg && free_any && cnt_reg[0] < CW'(SLOTS);
                q_waddr = qaddr(2'd0, pos_add(head_reg[0], cnt_reg[0]));
                q_wdata = free_idx;
            end
            S_REPORT: begin
                wk_we = pend_reg && !term_reg && used_reg != '0 && used_reg < rep_q;
                q_we = pend_reg && !term_reg && !wk_we && cnt_reg[dem_lvl] < CW'(SLOTS);
                q_waddr = qaddr(dem_lvl, pos_add(head_reg[dem_lvl], cnt_reg[dem_lvl]));
                q_wdata = run_slot_reg;
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            for (int l = 0; l < 3; l++) begin
                head_reg[l] <= '0;
                cnt_reg[l] <= '0;
            end
            in_use_reg <= '0;
            blk_v_reg <= '0;
            clk_reg <= '0;
            run_slot_reg <= '0;
            run_lvl_reg <= '0;
            pend_reg <= 1'b0;
            idx_reg <= '0;
            lvl_reg <= '0;
            done <= 1'b0;
        end else begin
            done <= 1'b0;
            unique case (state_reg)
                S_IDLE: begin
                    if (start) begin
                        admit_reg <= admit;
                        used_reg <= used_ns;
                        term_reg <= term;
                        idx_reg <= '0;
                        state_reg <= op ? S_REPORT : S_SCAN;
                    end
                end
                S_SCAN: state_reg <= S_WAKE_CHK;
                S_WAKE_CHK: begin
                    if (blk_v_reg[idx_reg] && expired) begin
                        blk_v_reg[idx_reg] <= 1'b0;
                        if (cnt_reg[0] < CW'(SLOTS)) cnt_reg[0] <= cnt_reg[0] + 1'b1;
                    end
                    if (idx_reg == SW'(SLOTS - 1)) begin
                        state_reg <= S_ADMIT;
                    end else begin
                        idx_reg <= idx_reg + 1'b1;
                        state_reg <= S_SCAN;
                    end
                end
                S_ADMIT: begin
                    r_admitted <= admit_reg && free_any;
                    r_admit_slot <= (admit_reg && free_any) ? 5'(free_idx) : 5'd0;
                    if (admit_reg && free_any) begin
                        in_use_reg[free_idx] <= 1'b1;
                        if (cnt_reg[0] < CW'(SLOTS)) cnt_reg[0] <= cnt_reg[0] + 1'b1;
                    end
                    state_reg <= S_DISP;
                end
                S_DISP: begin
                    if (sel_any) begin
                        lvl_reg <= sel_lvl;
                        head_reg[sel_lvl] <= pos_add(head_reg[sel_lvl], CW'(1));
                        cnt_reg[sel_lvl] <= cnt_reg[sel_lvl] - 1'b1;
                        state_reg <= S_DISP_RD;
                    end else begin
                        clk_reg <= clock_add(clk_reg, idle_adv);
                        r_clock <= clock_add(clk_reg, idle_adv);
                        r_status <= ST_IDLE;
                        r_slot <= '0;
                        r_quantum <= '0;
                        done <= 1'b1;
                        state_reg <= S_IDLE;
                    end
                end
                S_DISP_RD: begin
                    run_slot_reg <= q_rdata;
                    run_lvl_reg <= lvl_reg;
                    pend_reg <= 1'b1;
                    clk_reg <= clock_add(clk_reg, disp_cost);
                    r_clock <= clock_add(clk_reg, disp_cost);
                    r_status <= ST_DISPATCH;
                    r_slot <= 5'(q_rdata);
                    r_quantum <= quantum_for(base_q, lvl_reg);
                    done <= 1'b1;
                    state_reg <= S_IDLE;
                end
                S_REPORT: begin
                    r_quantum <= '0;
                    r_admitted <= 1'b0;
                    r_admit_slot <= '0;
                    done <= 1'b1;
                    state_reg <= S_IDLE;
                    if (!pend_reg) begin
                        r_status <= ST_IGNORED;
                        r_slot <= '0;
                        r_clock <= clk_reg;
                    end else begin
                        pend_reg <= 1'b0;
                        clk_reg <= rep_clk;
                        r_clock <= rep_clk;
                        r_slot <= 5'(run_slot_reg);
                        if (term_reg) begin
                            in_use_reg[run_slot_reg] <= 1'b0;
                            r_status <= ST_FREED;
                        end else if (wk_we) begin
                            r_status <= ST_BLOCKED;
                            if (!(&blk_v_reg)) begin
                                blk_v_reg[blk_free] <= 1'b1;
                                blk_s_reg[blk_free] <= run_slot_reg;
                            end
                        end else begin
                            r_status <= ST_DEMOTED;
                            if (cnt_reg[dem_lvl] < CW'(SLOTS))
                                cnt_reg[dem_lvl] <= cnt_reg[dem_lvl] + 1'b1;
                        end
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign busy = (state_reg != S_IDLE);

    `MFS_ASSERT_IMP(a_start_idle, aclk, aresetn, start, state_reg == S_IDLE)
    `MFS_ASSERT_NXT(a_done_idle, aclk, aresetn, done, state_reg == S_IDLE)
    `MFS_ASSERT_IMP(a_cnt_max, aclk, aresetn, 1'b1, cnt_reg[0] <= CW'(SLOTS))
    `MFS_ASSERT_NXT(a_disp_pend, aclk, aresetn, state_reg == S_DISP_RD, pend_reg)
endmodule

>>> rtl/core/multilevel_feedback_scheduler.sv
`timescale 1ns / 1ps
// Channel  | tdata fields (low bit first)                                    | tuser
// s_ input | used_ns[29:0], terminated[30], zero pad; 4 bytes                | operation, admit
// m_ result| status, slot, quantum_ns, admitted, admit_slot, clock_sec,      | -
//          | clock_ns; 106 bits, zero pad to 14 bytes                         |
// Schedule item: blocked list scan (S_SCAN, S_WAKE_CHK per entry, through the
// wake memory read port), then S_ADMIT, S_DISP, S_DISP_RD. Report item: S_REPORT.
// One item at a time; s_tready stays low from acceptance until the result is taken.
// Reset is synchronous, active low; s_tready waits while the result is held.
module multilevel_feedback_scheduler
    import mfs_pkg::*;
#(
    parameter int SLOTS = 32
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [31:0]  s_tdata,   // used_ns, terminated
    input  logic [1:0]   s_tuser,   // operation, admit
    output logic         m_tvalid,
    input  logic         m_tready,
    // status, slot, quantum_ns, admitted, admit_slot, clock_sec, clock_ns
    output logic [111:0] m_tdata,
    input  logic         cfg_we,
    input  logic [1:0]   cfg_index,
    input  logic [29:0]  cfg_data
);
    logic [27:0] base_reg;
    logic [29:0] idle_reg, cost_reg;
    logic [7:0] wait_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            base_reg <= 28'd20000000;
            idle_reg <= 30'd10000000;
            cost_reg <= 30'd1000;
            wait_reg <= 8'd2;
        end else if (cfg_we) begin
            unique case (cfg_index)
                REG_BASE: base_reg <= cfg_data[27:0];
                REG_IDLE: idle_reg <= cfg_data;
                REG_COST: cost_reg <= cfg_data;
                REG_WAIT: wait_reg <= cfg_data[7:0];
                default: ;
            endcase
        end
    end

    logic busy, done, start;
    logic [2:0] r_status;
    logic [4:0] r_slot, r_admit_slot;
    logic [29:0] r_quantum;
    logic r_admitted;
    mfs_time_t r_clock;

    assign s_tready = !busy && !m_tvalid && !done;
    assign start = s_tvalid && s_tready;

    mfs_core #(.SLOTS(SLOTS)) u_core (
        .aclk(aclk), .aresetn(aresetn), .start(start),
        .op(s_tuser[0]), .admit(s_tuser[1]), .used_ns(s_tdata[29:0]), .term(s_tdata[30]),
        .base_q(base_reg), .idle_adv(idle_reg), .disp_cost(cost_reg), .wait_sec(wait_reg),
        .busy(busy), .done(done), .r_status(r_status), .r_slot(r_slot),
        .r_quantum(r_quantum), .r_admitted(r_admitted), .r_admit_slot(r_admit_slot),
        .r_clock(r_clock)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid <= 1'b0;
        end else if (done) begin
            m_tvalid <= 1'b1;
        end else if (m_tready) begin
            m_tvalid <= 1'b0;
        end
    end

    assign m_tdata = {6'd0, r_clock.ns, r_clock.sec, r_admit_slot, r_admitted,
                      r_quantum, r_slot, r_status};
endmodule
